// ----- design/mei_pkg.sv -----
package mei_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int COORD_BITS = 12;

    localparam int Z_W       = FRAC_BITS + 4;
    localparam int PROD_W    = 2 * Z_W;
    localparam int CNT_W     = 16;
    localparam int ORIG_W    = 32;
    localparam int STEP_W    = 31;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // pixel offset times step
    localparam int CPRD_W  = COORD_BITS + STEP_W;
    localparam int C_SUM_W = ((ORIG_W > CPRD_W + 1) ? ORIG_W : CPRD_W + 1) + 1;

    // z update: difference or doubled cross product, floor-shifted, then clamped
    localparam int SH_W     = PROD_W + 1 - FRAC_BITS;
    localparam int CL_W     = (SH_W > 63) ? SH_W : 63;
    localparam int SAT_IN_W = ((CL_W > C_SUM_W) ? CL_W : C_SUM_W) + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_REAL    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IMAG    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = CFG_IDX_W'(3);

    localparam logic signed [ORIG_W-1:0] ORIGIN_REAL_RST = -32'sd563714458;
    localparam logic signed [ORIG_W-1:0] ORIGIN_IMAG_RST = -32'sd322122547;
    localparam logic [STEP_W-1:0]        PIXEL_STEP_RST  = STEP_W'(1342177);
    localparam logic [CNT_W-1:0]         MAX_ITER_RST    = CNT_W'(50);

    // |z|^2 threshold of 4 at 2*FRAC_BITS fraction bits
    localparam logic [PROD_W:0] ESC_LIM = {{(PROD_W - 2*FRAC_BITS - 2){1'b0}}, 1'b1,
                                           {(2*FRAC_BITS + 2){1'b0}}};

    localparam logic signed [CL_W-1:0] CLAMP_POS = {{(CL_W-62){1'b0}}, 1'b1, 61'b0};
    localparam logic signed [CL_W-1:0] CLAMP_NEG = -CLAMP_POS;

    localparam logic signed [SAT_IN_W-1:0] Z_MAX = {{(SAT_IN_W-Z_W+1){1'b0}},
                                                   {(Z_W-1){1'b1}}};
    localparam logic signed [SAT_IN_W-1:0] Z_MIN = ~Z_MAX;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0] iteration_count;
        logic             inside_set;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic c_init;
        logic mul;
        logic step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic escaped;
        logic at_limit;
    } t_dp_stat;

    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SAT_IN_W-1:0] v);
        logic signed [Z_W-1:0] r;
        if (v > Z_MAX) begin
            r = Z_MAX[Z_W-1:0];
        end else if (v < Z_MIN) begin
            r = Z_MIN[Z_W-1:0];
        end else begin
            r = v[Z_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [CL_W-1:0] clamp_big(input logic signed [SH_W-1:0] v);
        logic signed [CL_W-1:0] w;
        logic signed [CL_W-1:0] r;
        w = CL_W'(v);
        if (w > CLAMP_POS) begin
            r = CLAMP_POS;
        end else if (w < CLAMP_NEG) begin
            r = CLAMP_NEG;
        end else begin
            r = w;
        end
        return r;
    endfunction

endpackage

// ----- design/mei_datapath.sv -----
module mei_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mei_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mei_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  mei_pkg::t_in_item                i_in_item,
    input  mei_pkg::t_dp_cmd                 i_cmd,
    output mei_pkg::t_dp_stat                o_stat,
    output mei_pkg::t_out_item               o_res
);

    logic signed [mei_pkg::ORIG_W-1:0]   r_origin_r;
    logic signed [mei_pkg::ORIG_W-1:0]   r_origin_i;
    logic        [mei_pkg::STEP_W-1:0]   r_step;
    logic        [mei_pkg::CNT_W-1:0]    r_max_iter;

    logic        [mei_pkg::CPRD_W-1:0]   r_px_prod;
    logic        [mei_pkg::CPRD_W-1:0]   r_py_prod;
    logic signed [mei_pkg::Z_W-1:0]      r_cr;
    logic signed [mei_pkg::Z_W-1:0]      r_ci;
    logic signed [mei_pkg::Z_W-1:0]      r_zr;
    logic signed [mei_pkg::Z_W-1:0]      r_zi;
    logic signed [mei_pkg::PROD_W-1:0]   r_sq_r;
    logic signed [mei_pkg::PROD_W-1:0]   r_sq_i;
    logic signed [mei_pkg::PROD_W-1:0]   r_cross;
    logic        [mei_pkg::CNT_W-1:0]    r_k;
    mei_pkg::t_out_item                  r_res;

    logic        [mei_pkg::PROD_W:0]     mag_sum;
    logic signed [mei_pkg::PROD_W:0]     diff;
    logic signed [mei_pkg::PROD_W:0]     cross2;
    logic signed [mei_pkg::CL_W-1:0]     diff_cl;
    logic signed [mei_pkg::CL_W-1:0]     cross_cl;
    logic signed [mei_pkg::SAT_IN_W-1:0] zr_sum;
    logic signed [mei_pkg::SAT_IN_W-1:0] zi_sum;
    logic signed [mei_pkg::SAT_IN_W-1:0] cr_sum;
    logic signed [mei_pkg::SAT_IN_W-1:0] ci_sum;
    logic        [mei_pkg::CNT_W-1:0]    n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_r <= mei_pkg::ORIGIN_REAL_RST;
            r_origin_i <= mei_pkg::ORIGIN_IMAG_RST;
            r_step     <= mei_pkg::PIXEL_STEP_RST;
            r_max_iter <= mei_pkg::MAX_ITER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mei_pkg::CFG_ORIGIN_REAL:    r_origin_r <= i_cfg_data[mei_pkg::ORIG_W-1:0];
                mei_pkg::CFG_ORIGIN_IMAG:    r_origin_i <= i_cfg_data[mei_pkg::ORIG_W-1:0];
                mei_pkg::CFG_PIXEL_STEP:     r_step     <= i_cfg_data[mei_pkg::STEP_W-1:0];
                mei_pkg::CFG_MAX_ITERATIONS: r_max_iter <= i_cfg_data[mei_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // products are non-negative, so the sum cannot wrap at this width
    assign mag_sum = {1'b0, r_sq_r} + {1'b0, r_sq_i};
    assign diff    = (mei_pkg::PROD_W+1)'(r_sq_r) - (mei_pkg::PROD_W+1)'(r_sq_i);
    assign cross2  = {r_cross, 1'b0};

    // dropping the low fraction bits of a signed value floors it
    assign diff_cl  = mei_pkg::clamp_big(diff[mei_pkg::PROD_W:mei_pkg::FRAC_BITS]);
    assign cross_cl = mei_pkg::clamp_big(cross2[mei_pkg::PROD_W:mei_pkg::FRAC_BITS]);

    assign zr_sum = mei_pkg::SAT_IN_W'(diff_cl) + mei_pkg::SAT_IN_W'(r_cr);
    assign zi_sum = mei_pkg::SAT_IN_W'(cross_cl) + mei_pkg::SAT_IN_W'(r_ci);

    assign cr_sum = mei_pkg::SAT_IN_W'(r_origin_r) + $signed(mei_pkg::SAT_IN_W'(r_px_prod));
    assign ci_sum = mei_pkg::SAT_IN_W'(r_origin_i) + $signed(mei_pkg::SAT_IN_W'(r_py_prod));

    assign o_stat.escaped  = (mag_sum >= mei_pkg::ESC_LIM);
    assign o_stat.at_limit = (r_k >= r_max_iter);

    // escape is only possible after at least one iteration
    assign n_count = o_stat.escaped ? (r_k - mei_pkg::CNT_W'(1)) : r_max_iter;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px_prod <= mei_pkg::CPRD_W'(i_in_item.pixel_x) * mei_pkg::CPRD_W'(r_step);
            r_py_prod <= mei_pkg::CPRD_W'(i_in_item.pixel_y) * mei_pkg::CPRD_W'(r_step);
        end
        if (i_cmd.c_init) begin
            r_cr <= mei_pkg::sat_z(cr_sum);
            r_ci <= mei_pkg::sat_z(ci_sum);
            r_zr <= '0;
            r_zi <= '0;
            r_k  <= '0;
        end
        if (i_cmd.mul) begin
            r_sq_r  <= mei_pkg::PROD_W'(r_zr) * mei_pkg::PROD_W'(r_zr);
            r_sq_i  <= mei_pkg::PROD_W'(r_zi) * mei_pkg::PROD_W'(r_zi);
            r_cross <= mei_pkg::PROD_W'(r_zr) * mei_pkg::PROD_W'(r_zi);
        end
        if (i_cmd.step) begin
            r_zr <= mei_pkg::sat_z(zr_sum);
            r_zi <= mei_pkg::sat_z(zi_sum);
            r_k  <= r_k + mei_pkg::CNT_W'(1);
        end
        if (i_cmd.finish) begin
            r_res.iteration_count <= n_count;
            r_res.inside_set      <= !o_stat.escaped;
        end
    end

    assign o_res = r_res;

endmodule

// ----- design/mei_ctrl.sv -----
module mei_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  mei_pkg::t_dp_stat i_stat,
    output mei_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CINIT,
        S_MUL,
        S_TEST
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   done;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign done       = i_stat.escaped || i_stat.at_limit;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && i_out_stall;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CINIT;
                end
            end
            S_CINIT: begin
                o_cmd.c_init = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_TEST;
            end
            S_TEST: begin
                if (done) begin
                    // hold here until the output register can take the item
                    if (out_free) begin
                        o_cmd.finish = 1'b1;
                        n_out_valid  = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_MUL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- design/mandelbrot_escape_iteration_unit.sv -----
// an accepted item is loaded, c is initialised, then the z loop runs until escape or the
// iteration limit, and the result is registered once the output register is free
// a new item is taken only while idle, after the previous one has finished; each z loop
// iteration runs a multiply stage and an escape test / update stage around the registered products
// reset: synchronous active low, clears the controller and loads the register defaults
// the result register lets the next item enter while a result is still stalled
module mandelbrot_escape_iteration_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  mei_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mei_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mei_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mei_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    mei_pkg::t_dp_cmd  cmd;
    mei_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    mei_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mei_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res       (o_out_item)
    );

endmodule
